@@ hw/rtl/ppaf_pkg.sv @@
// Shared constants, types and the byte-to-prime map of the anagram filter.
package ppaf_pkg;

   localparam int MAX_WORD_DEF = 32;
   localparam int PROD_W       = 64;
   localparam int BYTE_W       = 8;

   localparam logic [BYTE_W-1:0] CR_CODE  = 8'h0D;
   localparam logic [PROD_W-1:0] PROD_ONE = 64'd1;

   typedef enum logic {
      ST_RUN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;   // an input beat is accepted this cycle
      logic load;   // load the next stored byte into the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skip;     // current beat is the one after a carriage return
      logic is_cr;    // current input byte ends a line
      logic match;    // line is valid, not empty, and the product hits the target
      logic rd_last;  // read pointer sits on the final stored byte
   } status_type;

   // Map a byte to its prime; zero marks an unmapped byte.
   function automatic logic [BYTE_W-1:0] char_prime(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] p;
      unique case (b)
         8'h20: p = 8'd139;
         8'h21: p = 8'd149;
         8'h27: p = 8'd151;
         8'h41, 8'h61: p = 8'd2;
         8'h42, 8'h62: p = 8'd3;
         8'h43, 8'h63: p = 8'd5;
         8'h44, 8'h64: p = 8'd7;
         8'h45, 8'h65: p = 8'd11;
         8'h46, 8'h66: p = 8'd13;
         8'h47, 8'h67: p = 8'd17;
         8'h48, 8'h68: p = 8'd19;
         8'h49, 8'h69: p = 8'd23;
         8'h4A, 8'h6A: p = 8'd29;
         8'h4B, 8'h6B: p = 8'd31;
         8'h4C, 8'h6C: p = 8'd37;
         8'h4D, 8'h6D: p = 8'd41;
         8'h4E, 8'h6E: p = 8'd43;
         8'h4F, 8'h6F: p = 8'd47;
         8'h50, 8'h70: p = 8'd53;
         8'h51, 8'h71: p = 8'd59;
         8'h52, 8'h72: p = 8'd61;
         8'h53, 8'h73: p = 8'd67;
         8'h54, 8'h74: p = 8'd71;
         8'h55, 8'h75: p = 8'd73;
         8'h56, 8'h76: p = 8'd79;
         8'h57, 8'h77: p = 8'd83;
         8'h58, 8'h78: p = 8'd89;
         8'h59, 8'h79: p = 8'd97;
         8'h5A, 8'h7A: p = 8'd101;
         8'hD0, 8'hF0: p = 8'd103;
         8'hD5, 8'hF5: p = 8'd107;
         8'hD6, 8'hF6: p = 8'd109;
         8'hC4, 8'hE4: p = 8'd113;
         8'hDC, 8'hFC: p = 8'd127;
         8'hDE, 8'hFE: p = 8'd131;
         8'hC9, 8'hE9: p = 8'd137;
         default: p = 8'd0;
      endcase
      return p;
   endfunction

endpackage

@@ hw/rtl/ppaf_dpath.sv @@
// Datapath: running prime product, line buffer, target register and result register.
module ppaf_dpath
   import ppaf_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              csr_wr_en,
   input  logic [PROD_W-1:0] csr_wr_data,
   input  cmd_type           cmd,
   output status_type        status,
   output logic [BYTE_W-1:0] rsp_word_byte,
   output logic              rsp_last_of_word
);

   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam int IDX_W = $clog2(MAX_WORD);

   logic [PROD_W-1:0] target_ff;
   logic [PROD_W-1:0] product_ff, product_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              invalid_ff, invalid_in;
   logic              skip_ff, skip_in;
   logic [LEN_W-1:0]  emit_len_ff, emit_len_in;
   logic [LEN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;

   logic [BYTE_W-1:0] word_mem [MAX_WORD];

   logic [BYTE_W-1:0]        prime;
   logic [PROD_W+BYTE_W-1:0] mul_full;
   logic                     is_cr;
   logic                     len_full;
   logic                     store_en;

   // Decode the incoming byte
   assign is_cr    = (req_data_byte == CR_CODE);
   assign prime    = char_prime(req_data_byte);
   assign mul_full = product_ff * prime;
   assign len_full = (length_ff == LEN_W'(MAX_WORD));
   assign store_en = cmd.take && !skip_ff && !is_cr && !len_full;

   assign status.skip    = skip_ff;
   assign status.is_cr   = is_cr;
   assign status.match   = !invalid_ff && (length_ff != '0) && (product_ff == target_ff);
   assign status.rd_last = (rd_cnt_ff == (emit_len_ff - LEN_W'(1)));

   // Line state update per accepted beat and read pointer advance
   always_comb begin
      product_in  = product_ff;
      length_in   = length_ff;
      invalid_in  = invalid_ff;
      skip_in     = skip_ff;
      emit_len_in = emit_len_ff;
      rd_cnt_in   = rd_cnt_ff;
      if (cmd.take) begin
         priority if (skip_ff) begin
            skip_in = 1'b0;
         end else if (is_cr) begin
            emit_len_in = length_ff;
            rd_cnt_in   = '0;
            product_in  = PROD_ONE;
            length_in   = '0;
            invalid_in  = 1'b0;
            skip_in     = 1'b1;
         end else begin
            if (len_full) begin
               invalid_in = 1'b1;
            end else begin
               length_in = length_ff + LEN_W'(1);
            end
            if (prime == '0) begin
               invalid_in = 1'b1;
            end else begin
               product_in = mul_full[PROD_W-1:0];
            end
         end
      end
      if (cmd.load) begin
         rd_cnt_in = rd_cnt_ff + LEN_W'(1);
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= PROD_ONE;
         product_ff  <= PROD_ONE;
         length_ff   <= '0;
         invalid_ff  <= 1'b0;
         skip_ff     <= 1'b0;
         emit_len_ff <= '0;
         rd_cnt_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         product_ff  <= product_in;
         length_ff   <= length_in;
         invalid_ff  <= invalid_in;
         skip_ff     <= skip_in;
         emit_len_ff <= emit_len_in;
         rd_cnt_ff   <= rd_cnt_in;
      end
   end

   // Store line bytes; read one into the result register per load
   always_ff @(posedge clock) begin
      if (store_en) begin
         word_mem[length_ff[IDX_W-1:0]] <= req_data_byte;
      end
      if (cmd.load) begin
         byte_ff <= word_mem[rd_cnt_ff[IDX_W-1:0]];
         last_ff <= status.rd_last;
      end
   end

   assign rsp_word_byte    = byte_ff;
   assign rsp_last_of_word = last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(MAX_WORD))
      else $error("line length beyond buffer depth");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (rd_cnt_ff < emit_len_ff))
      else $error("read beyond stored word");

   a_cr_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && !skip_ff && is_cr) |=> (length_ff == '0) && skip_ff && !invalid_ff)
      else $error("line state not cleared after carriage return");

endmodule

@@ hw/rtl/ppaf_ctrl.sv @@
// Controller: input/result handshakes and the word emission sequence.
module ppaf_ctrl
   import ppaf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Result register can take a new beat when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.take     = 1'b0;
      cmd.load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && !status.skip && status.is_cr && status.match) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.rd_last) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_on_match: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && !status.skip && status.is_cr && status.match) |=> (state_ff == ST_EMIT))
      else $error("matching line did not start emission");

   a_no_take_while_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && cmd.load))
      else $error("input taken during emission");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded beat not presented");

endmodule

@@ hw/rtl/prime_product_anagram_filter.sv @@
// A matching word's carriage return moves the controller to the emit state, which loads its first beat.
// One input byte per cycle outside emission; input stalls while a word is emitted,
// one byte per load via the line buffer's single read port; loads wait on result back-pressure.
// Reset (synchronous, active high) clears the product to one, the target to one,
// the line length, the invalid and skip marks and the result valid; no clearing pass.
module prime_product_anagram_filter
   import ppaf_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_word_byte,
   output logic              rsp_last_of_word,
   input  logic              csr_wr_en,
   input  logic [PROD_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   ppaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppaf_dpath #(
      .MAX_WORD (MAX_WORD)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_word_byte    (rsp_word_byte),
      .rsp_last_of_word (rsp_last_of_word)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the prime-product anagram filter: table-driven opening, then random word lists.
module tb;
   import ppaf_pkg::*;

   localparam int MAX_WORD     = MAX_WORD_DEF;
   localparam int RANDOM_ITEMS = 390;
   localparam int PHASE_ITEMS  = 60;
   localparam int SETTLE       = 6;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 24;
   localparam logic [BYTE_W-1:0] LF_CODE = 8'h0A;

   typedef enum logic [1:0] {
      SEND_PREDICTED,   // beat checked against the line predictor
      SEND_SILENT,      // beat that must not produce a word
      WRITE_TARGET      // load a new target product
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [PROD_W-1:0] value;
      logic [BYTE_W-1:0] data;
   } opening_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] word_byte;
      logic              last_of_word;
   } word_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_word_byte;
   logic              rsp_last_of_word;
   logic              csr_wr_en = 1'b0;
   logic [PROD_W-1:0] csr_wr_data = '0;

   // Line predictor state
   int unsigned       prime_map [256];
   logic [PROD_W-1:0] key_target = PROD_ONE;
   logic [PROD_W-1:0] line_prod = PROD_ONE;
   int                line_len = 0;
   logic [BYTE_W-1:0] line_buf [MAX_WORD];
   bit                skip_byte = 1'b0;
   bit                line_bad = 1'b0;

   word_beat_type     word_pending [$];
   int                mismatches = 0;
   int                cycle_count = 0;
   bit                steady = 1'b0;
   bit                hold_req = 1'b0;
   bit                hold_done = 1'b0;
   int                hold_left = 0;
   opening_row_type   opening [24];

   prime_product_anagram_filter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_byte    (rsp_word_byte),
      .rsp_last_of_word (rsp_last_of_word),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d word beats outstanding", $time, word_pending.size());
         $display("status: fail");
         $finish;
      end
   end

   // Advance the line predictor by one accepted beat; queue the word on a match
   function automatic void predict_byte(input logic [BYTE_W-1:0] b, input bit keep);
      word_beat_type beat;
      if (skip_byte) begin
         skip_byte = 1'b0;
         return;
      end
      if (b == CR_CODE) begin
         if (!line_bad && line_len != 0 && line_prod == key_target) begin
            for (int k = 0; k < line_len; k++) begin
               beat.word_byte    = line_buf[k];
               beat.last_of_word = (k == line_len - 1);
               if (keep) word_pending.push_back(beat);
            end
         end
         line_prod = PROD_ONE;
         line_len  = 0;
         line_bad  = 1'b0;
         skip_byte = 1'b1;
         return;
      end
      if (line_len < MAX_WORD) begin
         line_buf[line_len] = b;
         line_len++;
      end else begin
         line_bad = 1'b1;
      end
      if (prime_map[b] == 0) line_bad = 1'b1;
      else line_prod = line_prod * PROD_W'(prime_map[b]);
   endfunction

   // Offer one beat after a random gap, hold it until accepted
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit keep);
      int gap;
      gap = 0;
      if (!steady) begin
         while (gap < 8 && $urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, keep);
   endtask

   // Drain outstanding words, let the block settle, then load the target
   task automatic write_target(input logic [PROD_W-1:0] value);
      req_valid <= 1'b0;
      while (word_pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      key_target = value;
   endtask

   // Check each result beat and pace the result side
   always @(posedge clock) begin : result_side
      word_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (word_pending.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                     $time, rsp_word_byte, rsp_last_of_word);
            mismatches++;
         end else begin
            want = word_pending.pop_front();
            if (rsp_word_byte !== want.word_byte) begin
               $display("%0t: word_byte mismatch, expected %02h, actual %02h",
                        $time, want.word_byte, rsp_word_byte);
               mismatches++;
            end
            if (rsp_last_of_word !== want.last_of_word) begin
               $display("%0t: last_of_word mismatch, expected %0b, actual %0b",
                        $time, want.last_of_word, rsp_last_of_word);
               mismatches++;
            end
         end
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_done && rsp_valid) begin
         // hold off long enough for the block to back up into its input
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin : stimulus
      int unsigned       letter_primes [26];
      logic [BYTE_W-1:0] estonian_upper [7];
      int unsigned       estonian_primes [7];
      logic [BYTE_W-1:0] mapped_bytes [$];
      logic [BYTE_W-1:0] key_bytes [$];
      logic [BYTE_W-1:0] line_bytes [$];
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] tmp;
      logic [PROD_W-1:0] target;
      int                key_len;
      int                pick;
      int                j;
      int                phase;
      int                phase_bytes;
      int                sent;

      // Build the byte-to-prime map: letters in both cases, Estonian letters, punctuation
      letter_primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61,
                        67, 71, 73, 79, 83, 89, 97, 101};
      estonian_upper  = '{8'hD0, 8'hD5, 8'hD6, 8'hC4, 8'hDC, 8'hDE, 8'hC9};
      estonian_primes = '{103, 107, 109, 113, 127, 131, 137};
      for (int i = 0; i < 256; i++) prime_map[i] = 0;
      for (int i = 0; i < 26; i++) begin
         prime_map[8'h41 + i] = letter_primes[i];
         prime_map[8'h61 + i] = letter_primes[i];
      end
      for (int i = 0; i < 7; i++) begin
         prime_map[estonian_upper[i]]          = estonian_primes[i];
         prime_map[estonian_upper[i] | 8'h20] = estonian_primes[i];
      end
      prime_map[8'h20] = 139;
      prime_map[8'h21] = 149;
      prime_map[8'h27] = 151;
      for (int i = 0; i < 256; i++) begin
         if (prime_map[i] != 0) mapped_bytes.push_back(BYTE_W'(i));
      end

      // Opening rows: target 1 from reset, then a five-byte key, then the extremes
      opening = '{
         '{SEND_SILENT,    64'd0, 8'h0D},  // empty line: product matches, nothing out
         '{SEND_SILENT,    64'd0, 8'h0D},  // CR right after CR is dropped
         '{SEND_SILENT,    64'd0, 8'h00},  // unmapped byte poisons the line
         '{SEND_SILENT,    64'd0, 8'h0D},
         '{SEND_SILENT,    64'd0, 8'h0A},  // dropped
         '{SEND_SILENT,    64'd0, 8'h0A},  // line feed in a word is unmapped
         '{SEND_SILENT,    64'd0, 8'h0D},
         '{SEND_SILENT,    64'd0, 8'hFF},  // dropped
         // key u-umlaut, space, a, '!', apostrophe: 127 * 139 * 2 * 149 * 151
         '{WRITE_TARGET,   64'd794349694, 8'h00},
         '{SEND_PREDICTED, 64'd0, 8'h27},
         '{SEND_PREDICTED, 64'd0, 8'h21},
         '{SEND_PREDICTED, 64'd0, 8'h41},
         '{SEND_PREDICTED, 64'd0, 8'h20},
         '{SEND_PREDICTED, 64'd0, 8'hDC},
         '{SEND_PREDICTED, 64'd0, 8'h0D},
         '{SEND_PREDICTED, 64'd0, 8'h0A},
         '{WRITE_TARGET,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
         '{SEND_SILENT,    64'd0, 8'h7A},
         '{SEND_SILENT,    64'd0, 8'h0D},
         '{SEND_SILENT,    64'd0, 8'h0A},
         '{WRITE_TARGET,   64'd0, 8'h00},
         '{SEND_SILENT,    64'd0, 8'h61},
         '{SEND_SILENT,    64'd0, 8'h0D},
         '{SEND_SILENT,    64'd0, 8'h0A}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[r]) begin
         case (opening[r].kind)
            WRITE_TARGET:   write_target(opening[r].value);
            SEND_SILENT:    send_byte(opening[r].data, 1'b0);
            SEND_PREDICTED: send_byte(opening[r].data, 1'b1);
            default:        ;
         endcase
      end

      // Random phases: pick a key, load its product, stream mostly anagrams of it
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         key_bytes.delete();
         key_len = ($urandom_range(7) == 0) ? MAX_WORD : $urandom_range(1, 7);
         repeat (key_len) key_bytes.push_back(mapped_bytes[$urandom_range(mapped_bytes.size() - 1)]);
         target = PROD_ONE;
         foreach (key_bytes[i]) target = target * PROD_W'(prime_map[key_bytes[i]]);
         write_target(target);
         steady <= (phase == 2);
         if (phase == 4) hold_req <= 1'b1;

         phase_bytes = 0;
         while (phase_bytes < PHASE_ITEMS && sent + phase_bytes < RANDOM_ITEMS) begin
            line_bytes.delete();
            pick = $urandom_range(99);
            if (pick < 50) begin
               // shuffled key with random case, sometimes one byte spoiled
               line_bytes = key_bytes;
               for (int i = line_bytes.size() - 1; i > 0; i--) begin
                  j = $urandom_range(i);
                  tmp = line_bytes[i];
                  line_bytes[i] = line_bytes[j];
                  line_bytes[j] = tmp;
               end
               foreach (line_bytes[i]) begin
                  b = line_bytes[i] ^ 8'h20;
                  if (prime_map[b] == prime_map[line_bytes[i]] && $urandom_range(1) == 1)
                     line_bytes[i] = b;
               end
               if (pick >= 40) begin
                  b = BYTE_W'($urandom_range(255));
                  if (b == CR_CODE) b = 8'h00;
                  line_bytes[$urandom_range(line_bytes.size() - 1)] = b;
               end
            end else if (pick < 65) begin
               repeat ($urandom_range(1, 8))
                  line_bytes.push_back(mapped_bytes[$urandom_range(mapped_bytes.size() - 1)]);
            end else if (pick < 75) begin
               // overlong line
               repeat ($urandom_range(MAX_WORD + 1, MAX_WORD + 4))
                  line_bytes.push_back(mapped_bytes[$urandom_range(mapped_bytes.size() - 1)]);
            end else if (pick < 82) begin
               // empty line
            end else if (pick < 90) begin
               // key plus one extra mapped byte
               line_bytes = key_bytes;
               line_bytes.push_back(mapped_bytes[$urandom_range(mapped_bytes.size() - 1)]);
            end else begin
               // raw noise, stray CRs included
               repeat ($urandom_range(1, 6)) line_bytes.push_back(BYTE_W'($urandom_range(255)));
            end

            foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b1);
            send_byte(CR_CODE, 1'b1);
            send_byte(($urandom_range(9) == 0) ? BYTE_W'($urandom_range(255)) : LF_CODE, 1'b1);
            phase_bytes += line_bytes.size() + 2;
         end
         sent += phase_bytes;
         phase++;
      end

      // Drain and close
      req_valid <= 1'b0;
      steady    <= 1'b0;
      while (word_pending.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
